[design/smf_pkg.sv]
package smf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		sample_t sample_in;
		logic    last_in;
	} in_item_t;

	typedef struct packed {
		sample_t sample_out;
		logic    last_out;
	} out_item_t;

endpackage

[design/smf_cell.sv]
module smf_cell #(
	parameter int DEPTH = 15,
	parameter int IDX   = 0,
	parameter int JW    = 4,
	parameter int HW    = 3
) (
	input  logic            clk,
	input  logic            shift,
	input  smf_pkg::sample_t prev,
	input  smf_pkg::sample_t window [DEPTH],
	input  logic [JW-1:0]   span,
	input  logic [HW-1:0]   h,
	output smf_pkg::sample_t value,
	output logic            is_med
);
	import smf_pkg::*;

	sample_t          sample_q;
	logic [DEPTH-1:0] below;
	logic [JW-1:0]    rank;

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= prev;
		end
	end

	// rank within the window, ties broken by position
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			below[k] = (k <= int'(span)) && (k != IDX) &&
				((window[k] < sample_q) || ((k < IDX) && (window[k] == sample_q)));
		end
	end

	assign rank   = JW'($countones(below));
	assign is_med = (IDX <= int'(span)) && (rank == JW'(h));
	assign value  = sample_q;

endmodule

[design/smf_outq.sv]
module smf_outq #(
	parameter int NSLOT = 8,
	parameter int CW    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [CW-1:0]      load_cnt,
	input  logic               load_last,
	input  smf_pkg::sample_t   load_slots [NSLOT],
	input  logic               result_ready,
	output logic               result_valid,
	output smf_pkg::out_item_t result,
	output logic               free
);
	import smf_pkg::*;

	sample_t       slot_q [NSLOT];
	logic [CW-1:0] cnt_q;
	logic          last_q;
	logic          pop;

	assign result_valid = (cnt_q != '0);
	assign pop          = result_valid && result_ready;
	assign free         = (cnt_q == '0) || ((cnt_q == CW'(1)) && result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= load_cnt;
			last_q <= load_last;
		end else if (pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// results step toward slot zero, one per accepted item
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= load_slots;
		end else if (pop) begin
			for (int k = 0; k < NSLOT - 1; k++) begin
				slot_q[k] <= slot_q[k+1];
			end
		end
	end

	assign result.sample_out = slot_q[0];
	assign result.last_out   = last_q && (cnt_q == CW'(1));

endmodule

[design/sliding_median_filter_top.sv]
// sliding median filter over the gates of one radar beam. samples enter one item per clock
// on the sample channel while sample_ready is high, the last gate of a beam flagged by
// last_in. the half window h is window_length/2, clamped to MAX_HALF_WINDOW; gates in the
// interior of the beam are replaced by the median of the 2h+1 gates around them, the first
// and last h gates pass raw, and h = 0 passes everything. results leave in gate order on the
// result channel, h gates behind the input, with last_out on the final result of the beam. an
// accepted item passes through the cell row, where every cell ranks its sample against the
// window, then the output register. a gate that is not flagged last gives at most one result,
// so the filter sustains one item per clock while results are taken; the last gate gives up to
// h+1 results, which leave one per clock from the output register while result_ready is high.
// write window_length only while the block is idle.
module sliding_median_filter_top #(
	parameter int MAX_HALF_WINDOW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  smf_pkg::in_item_t  sample,
	output logic               result_valid,
	input  logic               result_ready,
	output smf_pkg::out_item_t result,
	input  logic               cfg_we,
	input  smf_pkg::len_t      cfg_data
);
	import smf_pkg::*;

	// store depth, counter and index widths
	localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
	localparam int SEEN_LIMIT = 2 * MAX_HALF_WINDOW;
	localparam int JW = $clog2(DEPTH);
	localparam int HW = $clog2(MAX_HALF_WINDOW + 1);
	localparam int SW = $clog2(DEPTH);
	localparam int NSLOT = MAX_HALF_WINDOW + 1;
	localparam int CW = $clog2(NSLOT + 1);

	// configuration and beam position
	len_t          cfg_q;
	logic [JW-1:0] seen_q;

	// item in the cell row
	logic          valid_s1;
	logic [JW-1:0] j_s1;
	logic          last_s1;

	logic          accept;
	logic          free;
	logic          load;

	logic [HW-1:0] h;
	logic [JW-1:0] span;
	sample_t       vals [DEPTH];
	sample_t       prev_val [DEPTH];
	logic [DEPTH-1:0] is_med;
	sample_t       median;
	logic          has_first;
	sample_t       first_val;
	logic [HW-1:0] m;
	logic [CW-1:0] cnt;
	logic [CW-1:0] base;
	logic [CW-1:0] idx;
	sample_t       slots [NSLOT];

	assign sample_ready = !valid_s1 || free;
	assign accept       = sample_valid && sample_ready;
	assign load         = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	// gates of the beam seen so far, saturating, cleared after the last gate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			if (sample.last_in) begin
				seen_q <= '0;
			end else if (seen_q < JW'(SEEN_LIMIT)) begin
				seen_q <= seen_q + JW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			j_s1    <= seen_q;
			last_s1 <= sample.last_in;
		end
	end

	// half window from the length register, clamped
	always_comb begin
		if (int'(cfg_q[LEN_W-1:1]) > MAX_HALF_WINDOW) begin
			h = HW'(MAX_HALF_WINDOW);
		end else begin
			h = HW'(cfg_q[LEN_W-1:1]);
		end
	end

	assign span = JW'({h, 1'b0});

	// row of cells: newest gate in cell zero, each cell hands its gate on as a new one enters
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign prev_val[g] = sample.sample_in;
		end else begin : g_body
			assign prev_val[g] = vals[g-1];
		end

		smf_cell #(
			.DEPTH(DEPTH),
			.IDX  (g),
			.JW   (JW),
			.HW   (HW)
		) u_cell (
			.clk   (clk),
			.shift (accept),
			.prev  (prev_val[g]),
			.window(vals),
			.span  (span),
			.h     (h),
			.value (vals[g]),
			.is_med(is_med[g])
		);
	end

	// exactly one cell of the window holds rank h
	always_comb begin
		median = '0;
		for (int k = 0; k < DEPTH; k++) begin
			median = median | (is_med[k] ? vals[k] : '0);
		end
	end

	// result list of the item in the cell row
	always_comb begin
		has_first = (j_s1 >= span) || (j_s1 >= JW'(h));
		first_val = (j_s1 >= span) ? median : vals[SW'(h)];
		if (!last_s1) begin
			m = '0;
		end else if ((j_s1 + JW'(1)) < JW'(h)) begin
			m = HW'(j_s1 + JW'(1));
		end else begin
			m = h;
		end
		cnt  = CW'(has_first) + CW'(m);
		base = cnt - CW'(1);
	end

	// edge gates flush oldest first, after the median or raw gate of this item
	always_comb begin
		idx = '0;
		for (int k = 0; k < NSLOT; k++) begin
			idx = base - CW'(k);
			if (has_first && (k == 0)) begin
				slots[k] = first_val;
			end else if (k < int'(cnt)) begin
				slots[k] = vals[SW'(idx)];
			end else begin
				slots[k] = '0;
			end
		end
	end

	smf_outq #(
		.NSLOT(NSLOT),
		.CW   (CW)
	) u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.load_cnt    (cnt),
		.load_last   (last_s1),
		.load_slots  (slots),
		.result_ready(result_ready),
		.result_valid(result_valid),
		.result      (result),
		.free        (free)
	);

endmodule

[design/smf_checker.sv]
module smf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input smf_pkg::in_item_t  sample,
	input logic               result_valid,
	input logic               result_ready,
	input smf_pkg::out_item_t result,
	input logic               cfg_we,
	input smf_pkg::len_t      cfg_data
);
	import smf_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// input backs up only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid)
		else $error("input stalled with no result pending");

	// a blocked output keeps the input blocked until the output frees up
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready && !result_ready |=> !sample_ready || result_ready)
		else $error("input freed while output still blocked");

	// a waiting input item holds
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(sample))
		else $error("input item changed while waiting");

	// length written only while idle
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !sample_valid && !result_valid && !$isunknown(cfg_data))
		else $error("length written while items in flight");

endmodule

bind sliding_median_filter_top smf_checker u_smf_checker (.*);
